// ===== src/tm_pkg.sv =====
// Package for triangle_metrics: widths, derived constants and shared types.
// No dependencies.
package tm_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PERIM_WIDTH = 27;
    localparam int AREA_WIDTH  = 33;

    // one triangle: vertices A, B, C
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by_coord;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } tri_t;

    // one result beat
    typedef struct packed {
        logic [PERIM_WIDTH-1:0]        perimeter_fixed;
        logic [AREA_WIDTH-1:0]         double_area;
        logic signed [COORD_WIDTH-1:0] centroid_x;
        logic signed [COORD_WIDTH-1:0] centroid_y;
    } metrics_t;
endpackage

// ===== src/tm_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface tm_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/tm_sqrt_cell.sv =====
// One restoring square-root digit cell: retires one root bit per beat while en is high.
// Depends on nothing besides its parameters.
module tm_sqrt_cell #(
    parameter int RW = 40,
    parameter int QW = 26
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [QW-1:0] root_in,
    input  logic [1:0]    pair,
    output logic [RW-1:0] rem_reg,
    output logic [QW-1:0] root_reg
);
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    always_comb
    begin
        sh    = {rem_in[RW-3:0], pair};
        trial = RW'({root_in, 2'b01});
    end
    // advance one digit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sh >= trial)
            begin
                rem_reg  <= sh - trial;
                root_reg <= {root_in[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sh;
                root_reg <= {root_in[QW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/tm_sqrt_chain.sv =====
// Chain of square-root cells: floor(sqrt(d2) * 2^FRAC) for even DW, one digit per stage.
// Depends on tm_sqrt_cell.
module tm_sqrt_chain #(
    parameter int DW   = 34,
    parameter int FRAC = 8
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [DW-1:0]              d2,
    output logic [(DW+1)/2+FRAC-1:0]   root
);
    localparam int NINT = (DW + 1) / 2;
    localparam int NST  = NINT + FRAC;
    localparam int QW   = NST;
    localparam int RW   = QW + 3;
    localparam int PW   = 2 * NST;
    logic [PW-1:0] rad;
    logic [RW-1:0] rem_w  [NST+1];
    logic [QW-1:0] root_w [NST+1];
    logic [PW-1:0] rad_w  [NST];
    assign rad       = PW'({d2, {(2*FRAC){1'b0}}}) << (2*NINT - DW);
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = rad;
    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_cell
            tm_sqrt_cell #(.RW(RW), .QW(QW)) u_cell (
                .clk(clk), .en(en), .rem_in(rem_w[g]), .root_in(root_w[g]),
                .pair(rad_w[g][PW-1:PW-2]),
                .rem_reg(rem_w[g+1]), .root_reg(root_w[g+1]));
            if (g < NST - 1)
            begin : g_rad
                logic [PW-1:0] rad_reg;
                // hand the remaining radicand bits on
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg <= rad_w[g] << 2;
                    end
                end
                assign rad_w[g+1] = rad_reg;
            end
        end
    endgenerate
    assign root = root_w[NST];
endmodule

// ===== src/triangle_metrics.sv =====
// Top level of triangle_metrics: input stage, three root chains, output stage.
// Depends on tm_pkg, tm_if and tm_sqrt_chain.
// One triangle enters every cycle when the sink keeps up; each result passes
// through the difference register, the square and product register, the
// digit-per-stage root chains (one stage per root bit) and the output
// register, which also forms the perimeter sum. The pipeline stalls as a
// whole when the result is not taken; the output register holds the waiting result.
module triangle_metrics #(
    parameter int COORD_WIDTH = tm_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = tm_pkg::FRAC_BITS
) (
    input logic clk,
    input logic rst_n,
    tm_if.sink   in_ch,
    tm_if.source out_ch
);
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = 2 * CW + 2;
    localparam int RTW  = (DW + 1) / 2 + FRAC_BITS;
    localparam int LAT  = RTW + 2;
    localparam int PW   = tm_pkg::PERIM_WIDTH;
    localparam int AW   = tm_pkg::AREA_WIDTH;
    localparam int XW   = 2 * CW + 3;
    localparam int DIVN = CW + 2;
    localparam logic [CW:0] RECIP3 = (CW+1)'(((1 << DIVN) + 2) / 3);

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = out_valid_reg;

    // stage 1: differences and sums
    logic signed [CW:0]   dxab_reg, dyab_reg, dxbc_reg, dybc_reg, dxca_reg, dyca_reg;
    logic signed [CW+1:0] sx_reg, sy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxab_reg <= $signed(in_ch.data.bx) - $signed(in_ch.data.ax);
            dyab_reg <= $signed(in_ch.data.by_coord) - $signed(in_ch.data.ay);
            dxbc_reg <= $signed(in_ch.data.cx) - $signed(in_ch.data.bx);
            dybc_reg <= $signed(in_ch.data.cy) - $signed(in_ch.data.by_coord);
            dxca_reg <= $signed(in_ch.data.ax) - $signed(in_ch.data.cx);
            dyca_reg <= $signed(in_ch.data.ay) - $signed(in_ch.data.cy);
            sx_reg   <= (CW+2)'($signed(in_ch.data.ax)) + $signed(in_ch.data.bx)
                        + $signed(in_ch.data.cx);
            sy_reg   <= (CW+2)'($signed(in_ch.data.ay)) + $signed(in_ch.data.by_coord)
                        + $signed(in_ch.data.cy);
        end
    end

    // divide the coordinate sums by 3: magnitude times reciprocal, sign restored
    logic [CW:0]       ux, uy;
    logic [2*CW+1:0]   mx, my;
    logic [CW-1:0]     qx, qy;
    always_comb
    begin
        ux = sx_reg[CW+1] ? (CW+1)'(-sx_reg) : (CW+1)'(sx_reg);
        uy = sy_reg[CW+1] ? (CW+1)'(-sy_reg) : (CW+1)'(sy_reg);
        mx = (2*CW+2)'(ux) * (2*CW+2)'(RECIP3);
        my = (2*CW+2)'(uy) * (2*CW+2)'(RECIP3);
        qx = mx[2*CW+1:DIVN];
        qy = my[2*CW+1:DIVN];
    end

    // stage 2: squares, cross products, centroid division by 3
    logic [DW-1:0] dab_reg, dbc_reg, dca_reg;
    logic signed [XW-1:0] p1_reg, p2_reg;
    logic signed [CW-1:0] gx_reg, gy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dab_reg <= DW'(dxab_reg) * DW'(dxab_reg) + DW'(dyab_reg) * DW'(dyab_reg);
            dbc_reg <= DW'(dxbc_reg) * DW'(dxbc_reg) + DW'(dybc_reg) * DW'(dybc_reg);
            dca_reg <= DW'(dxca_reg) * DW'(dxca_reg) + DW'(dyca_reg) * DW'(dyca_reg);
            p1_reg  <= XW'(dxab_reg) * XW'(-dyca_reg);
            p2_reg  <= XW'(dyab_reg) * XW'(-dxca_reg);
            gx_reg  <= sx_reg[CW+1] ? -qx : qx;
            gy_reg  <= sy_reg[CW+1] ? -qy : qy;
        end
    end

    // root chains advance with the rest of the pipeline
    logic [RTW-1:0] rab, rbc, rca;
    tm_sqrt_chain #(.DW(DW), .FRAC(FRAC_BITS)) u_ab (
        .clk(clk), .en(adv), .d2(dab_reg), .root(rab));
    tm_sqrt_chain #(.DW(DW), .FRAC(FRAC_BITS)) u_bc (
        .clk(clk), .en(adv), .d2(dbc_reg), .root(rbc));
    tm_sqrt_chain #(.DW(DW), .FRAC(FRAC_BITS)) u_ca (
        .clk(clk), .en(adv), .d2(dca_reg), .root(rca));

    // cross and centroid wait alongside the chains
    logic signed [XW-1:0] cr_d [RTW];
    logic signed [CW-1:0] gx_d [RTW];
    logic signed [CW-1:0] gy_d [RTW];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_d[0] <= p1_reg - p2_reg;
            gx_d[0] <= gx_reg;
            gy_d[0] <= gy_reg;
            for (int i = 1; i < RTW; i++)
            begin
                cr_d[i] <= cr_d[i-1];
                gx_d[i] <= gx_d[i-1];
                gy_d[i] <= gy_d[i-1];
            end
        end
    end

    // output register
    logic [PW-1:0] per_reg;
    logic [AW-1:0] area_reg;
    logic signed [CW-1:0] ox_reg, oy_reg;
    logic signed [XW-1:0] crl;
    assign crl = cr_d[RTW-1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            per_reg  <= PW'(rab) + PW'(rbc) + PW'(rca);
            area_reg <= AW'(crl < 0 ? -crl : crl);
            ox_reg   <= gx_d[RTW-1];
            oy_reg   <= gy_d[RTW-1];
        end
    end
    assign out_ch.data.perimeter_fixed = per_reg;
    assign out_ch.data.double_area     = area_reg;
    assign out_ch.data.centroid_x      = ox_reg;
    assign out_ch.data.centroid_y      = oy_reg;

    // valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_ch.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // hold a waiting result, keep the input open while the output is empty
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid);
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data));
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready);
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(out_ch.valid));
endmodule
